// ----- hw/rtl/pxu_pkg.sv -----
// Shared types and constants for the 2x pixel-art upscaler.
`timescale 1ns / 1ps

package pxu_pkg;

  // Field widths fixed by the stream format
  localparam int PIX_W      = 8;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 13;
  localparam int OUT_DATA_W = 56;

  // Queue between front and back
  localparam int QDEPTH   = 4;
  localparam int JOBS_MAX = 3;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // One result to compute: position plus the five pixels of the Scale2x cross
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] e;
    logic [PIX_W-1:0] f;
    logic [PIX_W-1:0] h;
    logic             done;
  } pxu_job_t;

  // Queue entry: all results caused by one input word, packed from slot 0
  typedef struct packed {
    logic [1:0]                 cnt;
    pxu_job_t [JOBS_MAX-1:0]    jobs;
  } pxu_entry_t;

endpackage

// ----- hw/rtl/pixel_art_2x_upscaler.sv -----
// Top level of the streaming Scale2x pixel-art upscaler.
// Input: one pixel word per clock while the queue has room. A result passes from the
// second stage through the queue into the output register, when the output is free.
// Output: one result word per clock while out_tready is high; one last-row pixel can
// cause up to three results, and the input then runs at the output rate, set by the single
// output register. Reset (rst_n, synchronous, low) clears position, queue and output;
// size registers go to one. Line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module pixel_art_2x_upscaler #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] pixel_value
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  // out_tdata: [8:0] src_col, [20:9] src_row, [28:21] out_top_left,
  // [36:29] out_top_right, [44:37] out_bottom_left, [52:45] out_bottom_right, zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pxu_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  // out_tuser: [0] image_done
  output logic [0:0]                       out_tuser,
  input  logic                             cfg_we,
  input  logic [pxu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pxu_pkg::CFG_W-1:0]        cfg_wdata
);
  import pxu_pkg::*;

  logic [WIDTH_W-1:0]  img_width_r, img_width_nxt;
  logic [HEIGHT_W-1:0] img_height_r, img_height_nxt;

  logic       push, full, pop, head_vld;
  pxu_entry_t push_entry, head;

  // Size registers
  always_comb begin
    img_width_nxt  = img_width_r;
    img_height_nxt = img_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_width_nxt  = cfg_wdata[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: img_height_nxt = cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= WIDTH_W'(1);
      img_height_r <= HEIGHT_W'(1);
    end else begin
      img_width_r  <= img_width_nxt;
      img_height_r <= img_height_nxt;
    end
  end

  pxu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .img_width  (img_width_r),
    .img_height (img_height_r),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  pxu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_vld   (head_vld)
  );

  pxu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_vld   (head_vld),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- hw/rtl/pxu_front.sv -----
// Front end: accepts pixels, runs the line stores and builds result jobs.
`timescale 1ns / 1ps

module pxu_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pxu_pkg::PIX_W-1:0]    in_tdata,
  input  logic [pxu_pkg::WIDTH_W-1:0]  img_width,
  input  logic [pxu_pkg::HEIGHT_W-1:0] img_height,
  output logic                         push,
  output pxu_pkg::pxu_entry_t          push_entry,
  input  logic                         full
);
  import pxu_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CWC = ((AW + 1) > WIDTH_W) ? (AW + 1) : WIDTH_W;
  localparam int CWR = ((RW + 1) > HEIGHT_W) ? (RW + 1) : HEIGHT_W;

  // Position counters
  logic [AW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CWC-1:0] col_p1;
  logic [CWR-1:0] row_p1;
  logic           last_col_a, last_row_a;
  logic           accept;
  logic [AW-1:0]  rd_addr1;

  // Line stores and their read data
  logic [PIX_W-1:0] mid_line_r [MAX_WIDTH];
  logic [PIX_W-1:0] up_line_r  [MAX_WIDTH];
  logic [PIX_W-1:0] mid0_rd_r, mid1_rd_r, up_rd_r;
  logic             byp_vld_r;
  logic [PIX_W-1:0] byp_pix_r;

  // Second stage
  logic             b_vld_r, b_vld_nxt;
  logic [PIX_W-1:0] b_px_r;
  logic [AW-1:0]    b_col_r;
  logic [RW-1:0]    b_row_r;
  logic             b_last_col_r, b_last_row_r;
  logic             b_go;

  // History of the stream
  logic [PIX_W-1:0] prev_m0_r;
  logic [PIX_W-1:0] px_d1_r, px_d2_r;

  // Job building
  logic [PIX_W-1:0] m0, u0;
  logic             c_ge1, c_ge2, r_ge1, r_ge2;
  logic             j1_en, j2_en, j3_en, has_jobs;
  pxu_job_t         j1, j2, j3;
  pxu_entry_t       entry;
  logic [1:0]       n_jobs;

  // Handshake
  assign accept    = in_tvalid && in_tready;
  assign in_tready = !b_vld_r || b_go;

  // End of row / end of image; zero width or height acts as one
  assign col_p1     = CWC'(col_r) + CWC'(1);
  assign row_p1     = CWR'(row_r) + CWR'(1);
  assign last_col_a = (col_p1 >= CWC'(img_width)) || (col_p1 >= CWC'(MAX_WIDTH));
  assign last_row_a = (row_p1 >= CWR'(img_height)) || (row_p1 >= CWR'(MAX_HEIGHT));
  assign rd_addr1   = last_col_a ? '0 : AW'(col_p1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col_a) begin
        col_nxt = '0;
        row_nxt = last_row_a ? '0 : RW'(row_p1);
      end else begin
        col_nxt = AW'(col_p1);
      end
    end
  end

  // Line stores: read before write at accept, upper row written as the word leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      mid0_rd_r           <= mid_line_r[col_r];
      mid1_rd_r           <= mid_line_r[rd_addr1];
      up_rd_r             <= up_line_r[col_r];
      mid_line_r[col_r]   <= in_tdata;
      byp_vld_r           <= b_go && (b_col_r == col_r);
      byp_pix_r           <= mid0_rd_r;
      b_px_r              <= in_tdata;
      b_col_r             <= col_r;
      b_row_r             <= row_r;
      b_last_col_r        <= last_col_a;
      b_last_row_r        <= last_row_a;
    end
    if (b_go) begin
      up_line_r[b_col_r] <= mid0_rd_r;
      px_d1_r            <= b_px_r;
      px_d2_r            <= px_d1_r;
    end
  end

  // Stage valid
  assign b_vld_nxt = accept ? 1'b1 : (b_go ? 1'b0 : b_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_vld_r   <= 1'b0;
      prev_m0_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      b_vld_r <= b_vld_nxt;
      if (b_go) begin
        prev_m0_r <= mid0_rd_r;
      end
    end
  end

  // Neighbor selection; upper store forwarded when written in the read cycle
  assign m0    = mid0_rd_r;
  assign u0    = byp_vld_r ? byp_pix_r : up_rd_r;
  assign c_ge1 = (b_col_r != '0);
  assign c_ge2 = c_ge1 && (b_col_r != AW'(1));
  assign r_ge1 = (b_row_r != '0);
  assign r_ge2 = r_ge1 && (b_row_r != RW'(1));

  assign j1_en    = r_ge1;
  assign j2_en    = b_last_row_r && c_ge1;
  assign j3_en    = b_last_row_r && b_last_col_r;
  assign has_jobs = j1_en || j2_en || j3_en;

  // Pixel above the incoming one
  always_comb begin
    j1.col  = COL_W'(b_col_r);
    j1.row  = ROW_W'(RW'(b_row_r - RW'(1)));
    j1.e    = m0;
    j1.b    = r_ge2 ? u0 : m0;
    j1.d    = c_ge1 ? prev_m0_r : m0;
    j1.f    = b_last_col_r ? m0 : mid1_rd_r;
    j1.h    = b_px_r;
    j1.done = 1'b0;
  end

  // Left neighbor in the last row
  always_comb begin
    j2.col  = COL_W'(AW'(b_col_r - AW'(1)));
    j2.row  = ROW_W'(b_row_r);
    j2.e    = px_d1_r;
    j2.d    = c_ge2 ? px_d2_r : px_d1_r;
    j2.b    = r_ge1 ? prev_m0_r : px_d1_r;
    j2.f    = b_px_r;
    j2.h    = px_d1_r;
    j2.done = 1'b0;
  end

  // Final pixel of the image
  always_comb begin
    j3.col  = COL_W'(b_col_r);
    j3.row  = ROW_W'(b_row_r);
    j3.e    = b_px_r;
    j3.d    = c_ge1 ? px_d1_r : b_px_r;
    j3.b    = r_ge1 ? m0 : b_px_r;
    j3.f    = b_px_r;
    j3.h    = b_px_r;
    j3.done = 1'b1;
  end

  // Pack the present jobs from slot 0 in stream order
  always_comb begin
    entry  = '0;
    n_jobs = '0;
    if (j1_en) begin
      entry.jobs[n_jobs] = j1;
      n_jobs             = n_jobs + 2'd1;
    end
    if (j2_en) begin
      entry.jobs[n_jobs] = j2;
      n_jobs             = n_jobs + 2'd1;
    end
    if (j3_en) begin
      entry.jobs[n_jobs] = j3;
      n_jobs             = n_jobs + 2'd1;
    end
    entry.cnt = n_jobs;
  end

  assign b_go       = b_vld_r && (!has_jobs || !full);
  assign push       = b_go && has_jobs;
  assign push_entry = entry;

  // Checks
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.cnt != 2'd0))
    else $error("front pushed an entry without jobs");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("front pushed into a full queue");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_col_a && last_row_a |=> (col_r == '0) && (row_r == '0))
    else $error("position did not return to origin after final pixel");

endmodule

// ----- hw/rtl/pxu_queue.sv -----
// Short queue of job entries between the front and back ends.
`timescale 1ns / 1ps

module pxu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pxu_pkg::pxu_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output pxu_pkg::pxu_entry_t head,
  output logic                head_vld
);
  import pxu_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  pxu_entry_t     slots_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == (PW + 1)'(QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = slots_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + PW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? PW'(rd_ptr_r + PW'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW + 1)'(QDEPTH))
    else $error("queue fill count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("queue popped while empty");

endmodule

// ----- hw/rtl/pxu_back.sv -----
// Back end: applies the Scale2x rule to each job and drives the result stream.
`timescale 1ns / 1ps

module pxu_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pxu_pkg::pxu_entry_t               head,
  input  logic                              head_vld,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pxu_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  output logic [0:0]                        out_tuser
);
  import pxu_pkg::*;

  logic [1:0]            idx_r, idx_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;
  logic                  out_done_r;

  pxu_job_t              job;
  logic                  load;
  logic                  last_job;
  logic                  active;
  logic [PIX_W-1:0]      tl, tr, bl, br;

  // Current job of the head entry
  assign job      = head.jobs[idx_r];
  assign last_job = (idx_r == (head.cnt - 2'd1));
  assign load     = head_vld && (!out_vld_r || out_tready);
  assign pop      = load && last_job;

  // Scale2x rule
  always_comb begin
    active = (job.b != job.h) && (job.d != job.f);
    tl = (active && (job.d == job.b)) ? job.d : job.e;
    tr = (active && (job.b == job.f)) ? job.f : job.e;
    bl = (active && (job.d == job.h)) ? job.d : job.e;
    br = (active && (job.h == job.f)) ? job.f : job.e;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_job ? 2'd0 : (idx_r + 2'd1);
    end
    out_vld_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= OUT_DATA_W'({br, bl, tr, tl, job.row, job.col});
      out_last_r <= last_job;
      out_done_r <= job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_done_r;

  // Checks
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("image end flagged on a word that does not end its run");

endmodule

// ----- sim/pxu_quad_checker.sv -----
// Scoreboard for the 2x upscaler: predicts each result word from the pixel stream and compares.
`timescale 1ns / 1ps

module pxu_quad_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // in_tdata: [7:0] pixel_value
  input  logic [7:0]                      in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [8:0] src_col, [20:9] src_row, [28:21] top_left, [36:29] top_right,
  // [44:37] bottom_left, [52:45] bottom_right, zero pad
  input  logic [pxu_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            out_tlast,
  // out_tuser: [0] image_done
  input  logic [0:0]                      out_tuser,
  input  logic                            cfg_we,
  input  logic [pxu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pxu_pkg::CFG_W-1:0]       cfg_wdata,
  output int                              fail_count,
  output int                              backlog
);
  import pxu_pkg::*;

  localparam int LINE_LEN = 512;
  localparam int MAX_ROWS = 4096;

  // One expanded source pixel as it should leave the block
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] br;
    logic             run_end;
    logic             done;
  } quad_t;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]    upper_row [LINE_LEN];
  logic [PIX_W-1:0]    mid_row   [LINE_LEN];
  logic [COL_W-1:0]    col_pos;
  logic [ROW_W-1:0]    row_pos;
  logic [PIX_W-1:0]    left_above;
  quad_t               quads_due [$];

  // Scale2x rule on the cross b (up), d (left), e (center), f (right), h (down)
  function automatic quad_t expand(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                                   input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] d,
                                   input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] f,
                                   input logic [PIX_W-1:0] h);
    quad_t q;
    q.col     = col;
    q.row     = row;
    q.tl      = e;
    q.tr      = e;
    q.bl      = e;
    q.br      = e;
    q.run_end = 1'b0;
    q.done    = 1'b0;
    if (b != h && d != f) begin
      if (d == b) q.tl = d;
      if (b == f) q.tr = f;
      if (d == h) q.bl = d;
      if (h == f) q.br = f;
    end
    return q;
  endfunction

  // Queue every result caused by one accepted pixel and advance the raster position
  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int unsigned     w;
    int unsigned     hgt;
    int unsigned     c;
    int unsigned     r;
    logic            last_col;
    logic            last_row;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] e;
    logic [PIX_W-1:0] f;
    quad_t           made [3];
    int              n;
    w   = (width_reg == '0) ? 1 :
          (32'(width_reg) > LINE_LEN) ? LINE_LEN : 32'(width_reg);
    hgt = (height_reg == '0) ? 1 :
          (32'(height_reg) > MAX_ROWS) ? MAX_ROWS : 32'(height_reg);
    c = 32'(col_pos);
    r = 32'(row_pos);
    n = 0;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= hgt);
    // pixel above the incoming one is now complete
    if (r >= 1) begin
      e = mid_row[COL_W'(c)];
      b = (r >= 2) ? upper_row[COL_W'(c)] : e;
      d = (c >= 1) ? left_above : e;
      f = (!last_col && c + 1 < LINE_LEN) ? mid_row[COL_W'(c + 1)] : e;
      made[n] = expand(COL_W'(c), ROW_W'(r - 1), b, d, e, f, px);
      n++;
    end
    left_above            = mid_row[COL_W'(c)];
    upper_row[COL_W'(c)]  = mid_row[COL_W'(c)];
    mid_row[COL_W'(c)]    = px;
    // bottom row: no row below, results trail by one pixel
    if (last_row) begin
      if (c >= 1) begin
        e = mid_row[COL_W'(c - 1)];
        d = (c >= 2) ? mid_row[COL_W'(c - 2)] : e;
        b = (r >= 1) ? upper_row[COL_W'(c - 1)] : e;
        made[n] = expand(COL_W'(c - 1), ROW_W'(r), b, d, e, px, e);
        n++;
      end
      if (last_col) begin
        d = (c >= 1) ? mid_row[COL_W'(c - 1)] : px;
        b = (r >= 1) ? upper_row[COL_W'(c)] : px;
        made[n] = expand(COL_W'(c), ROW_W'(r), b, d, px, px, px);
        made[n].done = 1'b1;
        n++;
      end
    end
    if (n > 0) made[n - 1].run_end = 1'b1;
    for (int i = 0; i < n; i++) quads_due.push_back(made[i]);
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Watch config, input and output words at each rising edge
  always @(posedge clk) begin : watch
    quad_t seen;
    quad_t want;
    if (!rst_n) begin
      width_reg  = 1;
      height_reg = 1;
      col_pos    = '0;
      row_pos    = '0;
      left_above = '0;
      quads_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        seen.col     = out_tdata[8:0];
        seen.row     = out_tdata[20:9];
        seen.tl      = out_tdata[28:21];
        seen.tr      = out_tdata[36:29];
        seen.bl      = out_tdata[44:37];
        seen.br      = out_tdata[52:45];
        seen.run_end = out_tlast;
        seen.done    = out_tuser[0];
        if (quads_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, got col %0d row %0d",
                   $time, seen.col, seen.row);
        end else begin
          want = quads_due.pop_front();
          check_field("src_col", 32'(want.col), 32'(seen.col));
          check_field("src_row", 32'(want.row), 32'(seen.row));
          check_field("top_left", 32'(want.tl), 32'(seen.tl));
          check_field("top_right", 32'(want.tr), 32'(seen.tr));
          check_field("bottom_left", 32'(want.bl), 32'(seen.bl));
          check_field("bottom_right", 32'(want.br), 32'(seen.br));
          check_field("run_end", 32'(want.run_end), 32'(seen.run_end));
          check_field("image_done", 32'(want.done), 32'(seen.done));
        end
      end
    end
    backlog = quads_due.size();
  end

endmodule

// ----- sim/tb_pixel_art_2x_upscaler.sv -----
// Testbench top for the 2x upscaler: image stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_pixel_art_2x_upscaler;
  import pxu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic [0:0]             out_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  int                     fail_count;
  int                     backlog;
  int                     cycles_run = 0;

  // flow-control knobs
  logic                   stall_free;
  logic                   hold_kick;
  logic                   hold_seen = 1'b0;
  int                     hold_left = 0;
  bit                     idle_free;

  // diagonal edges in two colors, hits every branch of the rule
  logic [7:0] diag_img [0:19] = '{
    8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00,
    8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF,
    8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF
  };

  pixel_art_2x_upscaler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pxu_quad_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, a stall-free stretch, and a long hold-off on request
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_free) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 8);
    end
  end

  function automatic int clamp_size(input int raw, input int top);
    return (raw == 0) ? 1 : (raw > top) ? top : raw;
  endfunction

  // Offer one pixel word, idling at random first; called and returns at a falling edge
  task automatic push_pixel(input logic [7:0] v);
    while (!idle_free && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stop sending until every expected word is out, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Reprogram the image size while idle; returns the pixel count of one image
  task automatic resize(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h,
                        output int npix);
    drain();
    write_reg(CFG_IMAGE_WIDTH, raw_w);
    write_reg(CFG_IMAGE_HEIGHT, raw_h);
    npix = clamp_size(int'(raw_w[WIDTH_W-1:0]), 512) * clamp_size(int'(raw_h), 4096);
  endtask

  // One image drawn mostly from a three-color palette so neighbors often match
  task automatic send_image(input int npix, input int pause_at);
    logic [7:0] pal [3];
    for (int i = 0; i < 3; i++) pal[i] = 8'($urandom_range(255));
    for (int i = 0; i < npix; i++) begin
      if (i == pause_at) drain();
      if ($urandom_range(99) < 85) push_pixel(pal[2'($urandom_range(2))]);
      else push_pixel(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int npix;
    int w;
    int h;
    int rand_pixels;
    int k;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_IMAGE_WIDTH;
    cfg_wdata  = '0;
    stall_free = 1'b0;
    hold_kick  = 1'b0;
    idle_free  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sizes from reset: a single-pixel image
    push_pixel(8'h5A);
    // zero sizes count as one
    resize(13'd0, 13'd0, npix);
    push_pixel(8'hFF);
    // two-color diagonals, final pixel flushes three words
    resize(13'd5, 13'd4, npix);
    for (int i = 0; i < 20; i++) push_pixel(diag_img[i]);
    // single row: everything trails by one pixel
    resize(13'd2, 13'd1, npix);
    push_pixel(8'h3C);
    push_pixel(8'hC3);
    // single column
    resize(13'd1, 13'd3, npix);
    push_pixel(8'h01);
    push_pixel(8'h02);
    push_pixel(8'h01);

    // random small images
    rand_pixels = 0;
    k = 0;
    while (rand_pixels < 240) begin
      if (k == 0) begin
        w = 10;
        h = 6;
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
      end
      // junk in the unused width bits; sometimes size one written as zero
      resize(CFG_W'(($urandom_range(7) << WIDTH_W) |
                    ((w == 1 && $urandom_range(1) == 1) ? 0 : w)),
             CFG_W'((h == 1 && $urandom_range(1) == 1) ? 0 : h), npix);
      stall_free <= (k >= 6 && k < 12);
      idle_free = (k >= 6 && k < 12);
      if (k == 0) hold_kick <= ~hold_kick;
      send_image(npix, (k == 3) ? npix / 2 : -1);
      rand_pixels += npix;
      k++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pxu_pkg.sv
hw/rtl/pxu_front.sv
hw/rtl/pxu_queue.sv
hw/rtl/pxu_back.sv
hw/rtl/pixel_art_2x_upscaler.sv
sim/pxu_quad_checker.sv
sim/tb_pixel_art_2x_upscaler.sv
